@@ hdl/trajectory_autocolor_macros.svh @@
// Assertion macros for the trajectory colorizer RTL.
`ifndef TRAJECTORY_AUTOCOLOR_MACROS_SVH
`define TRAJECTORY_AUTOCOLOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TAC_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TAC_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/tac_pkg.sv @@
// Shared codes and types of the trajectory colorizer.
package tac_pkg;

	// Color mode register codes; the unused code behaves as velocity.
	localparam logic [1:0] MODE_VEL = 2'd0;
	localparam logic [1:0] MODE_ACC = 2'd1;
	localparam logic [1:0] MODE_POS = 2'd2;

	// Register index of color_mode on the configuration port.
	localparam logic REG_COLOR_MODE = 1'b0;

	// Status of the queue between front and back.
	typedef struct packed {
		logic full;
		logic empty;
	} tac_qstat_t;

endpackage

@@ hdl/tac_front.sv @@
// Front end: accepts points, keeps the history and forms the color vector.
module tac_front #(
	parameter int POS_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [1:0]                color_mode,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [POS_BITS-1:0]       pos_x,
	input  logic [POS_BITS-1:0]       pos_y,
	input  logic [POS_BITS-1:0]       pos_z,
	input  logic                      clear_history,
	input  tac_pkg::tac_qstat_t       q_stat,
	output logic                      push,
	output logic [4*(POS_BITS+2)-1:0] push_data
);
	import tac_pkg::*;

	localparam int VW = POS_BITS + 2;

	logic [POS_BITS-1:0]  prev_q [3];
	logic [POS_BITS-1:0]  pbp_q [3];
	logic signed [VW-1:0] vec_s1 [3];
	logic                 valid_s1;

	logic [POS_BITS-1:0]  pt [3];
	logic signed [VW-1:0] pt_e [3];
	logic signed [VW-1:0] prv_e [3];
	logic signed [VW-1:0] pbp_e [3];
	logic signed [VW-1:0] vec_c [3];
	logic [VW-1:0]        mag [3];
	logic [VW-1:0]        big;
	logic                 accept;

	assign pt[0] = pos_x;
	assign pt[1] = pos_y;
	assign pt[2] = pos_z;

	assign in_ready = !valid_s1 || !q_stat.full;
	assign accept   = in_valid && in_ready;
	assign push     = valid_s1 && !q_stat.full;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pt_e[i]  = {{2{pt[i][POS_BITS-1]}}, pt[i]};
			prv_e[i] = clear_history ? '0 : {{2{prev_q[i][POS_BITS-1]}}, prev_q[i]};
			pbp_e[i] = clear_history ? '0 : {{2{pbp_q[i][POS_BITS-1]}}, pbp_q[i]};
			case (color_mode)
				MODE_ACC: vec_c[i] = pt_e[i] - (prv_e[i] <<< 1) + pbp_e[i];
				MODE_POS: vec_c[i] = pt_e[i];
				default:  vec_c[i] = pt_e[i] - prv_e[i];
			endcase
		end
	end

	// Largest magnitude is formed on the registered vector, in the push cycle.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = vec_s1[i][VW-1] ? VW'(-vec_s1[i]) : VW'(vec_s1[i]);
		end
		big = mag[0];
		if (mag[1] > big) begin
			big = mag[1];
		end
		if (mag[2] > big) begin
			big = mag[2];
		end
	end

	assign push_data = {big, vec_s1[2], vec_s1[1], vec_s1[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				prev_q[i] <= '0;
				pbp_q[i]  <= '0;
			end
		end else if (accept) begin
			valid_s1 <= 1'b1;
			for (int i = 0; i < 3; i++) begin
				pbp_q[i]  <= clear_history ? '0 : prev_q[i];
				prev_q[i] <= pt[i];
			end
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < 3; i++) begin
				vec_s1[i] <= vec_c[i];
			end
		end
	end

endmodule

@@ hdl/tac_queue.sv @@
// Short queue of color vectors between the front and the back end.
module tac_queue #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [WIDTH-1:0]    push_data,
	input  logic                pop,
	output logic [WIDTH-1:0]    pop_data,
	output tac_pkg::tac_qstat_t q_stat
);
	import tac_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign q_stat.full  = (count_q == CW'(DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign pop_data     = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ hdl/tac_back.sv @@
// Back end: three restoring divider lanes turn a vector into channel values.
module tac_back #(
	parameter int POS_BITS   = 16,
	parameter int COLOR_BITS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [4*(POS_BITS+2)-1:0] pop_data,
	input  tac_pkg::tac_qstat_t       q_stat,
	output logic                      pop,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [COLOR_BITS-1:0]     red,
	output logic [COLOR_BITS-1:0]     green,
	output logic [COLOR_BITS-1:0]     blue
);
	import tac_pkg::*;

	localparam int VW = POS_BITS + 2;
	localparam int NW = POS_BITS + COLOR_BITS + 6;
	localparam int KW = $clog2(COLOR_BITS);

	typedef enum logic [1:0] {BK_IDLE, BK_DIV, BK_DONE} bk_state_t;

	bk_state_t       state_q;
	logic [KW-1:0]   cnt_q;
	logic [NW-1:0]   rem_q [3];
	logic [NW-1:0]   den_q;
	logic [COLOR_BITS-1:0] quo_q [3];

	logic signed [NW-1:0] c_e [3];
	logic signed [NW-1:0] b_e;
	logic signed [NW-1:0] num_c [3];
	logic signed [NW-1:0] den_c;
	logic                 take_out;

	assign pop      = (state_q == BK_IDLE) && !q_stat.empty;
	assign take_out = (state_q == BK_DONE) && (!out_valid || out_ready);

	// Channel = floor((4*M*c + (6*M+5)*B) / (10*B)), M = 2^COLOR_BITS - 1.
	// A zero vector gives a zero divisor, so every quotient bit is set: white.
	always_comb begin
		b_e = {{(NW-VW){1'b0}}, pop_data[3*VW +: VW]};
		for (int i = 0; i < 3; i++) begin
			c_e[i]   = {{(NW-VW){pop_data[i*VW+VW-1]}}, pop_data[i*VW +: VW]};
			num_c[i] = (c_e[i] <<< (COLOR_BITS+2)) - (c_e[i] <<< 2)
				+ (b_e <<< (COLOR_BITS+2)) + (b_e <<< (COLOR_BITS+1)) - b_e;
		end
		den_c = ((b_e <<< 3) + (b_e <<< 1)) <<< (COLOR_BITS-1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			cnt_q     <= '0;
			out_valid <= 1'b0;
			red       <= '0;
			green     <= '0;
			blue      <= '0;
		end else begin
			if (out_valid && out_ready && !take_out) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				BK_IDLE: begin
					cnt_q <= '0;
					if (pop) begin
						state_q <= BK_DIV;
					end
				end
				BK_DIV: begin
					cnt_q <= cnt_q + KW'(1);
					if (cnt_q == KW'(COLOR_BITS-1)) begin
						state_q <= BK_DONE;
					end
				end
				BK_DONE: begin
					if (take_out) begin
						out_valid <= 1'b1;
						red       <= quo_q[0];
						green     <= quo_q[1];
						blue      <= quo_q[2];
						state_q   <= BK_IDLE;
					end
				end
				default: begin
					state_q <= BK_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			den_q <= NW'(den_c);
			for (int i = 0; i < 3; i++) begin
				rem_q[i] <= NW'(num_c[i]);
				quo_q[i] <= '0;
			end
		end else if (state_q == BK_DIV) begin
			den_q <= den_q >> 1;
			for (int i = 0; i < 3; i++) begin
				if (rem_q[i] >= den_q) begin
					rem_q[i] <= rem_q[i] - den_q;
					quo_q[i] <= {quo_q[i][COLOR_BITS-2:0], 1'b1};
				end else begin
					quo_q[i] <= {quo_q[i][COLOR_BITS-2:0], 1'b0};
				end
			end
		end
	end

endmodule

@@ hdl/trajectory_autocolor.sv @@
// Top level of the trajectory colorizer: ports, register file and assembly.
//
// Input beats on the s_ channel carry one trajectory point each (x, y, z in
// signed Q8.8) plus a clear_history flag in s_tuser that empties the two-point
// history before the point is used. Each input beat yields exactly one output
// beat on the m_ channel with red, green and blue intensities.
// The color_mode register on the APB-style port selects velocity (0),
// acceleration (1) or raw position (2) as the color vector; code 3 acts as
// velocity. Write it only while the block is idle. pready is always high.
// The three restoring divider lanes in the back end produce one quotient bit
// per cycle each; the back end takes no new vector from the queue until its
// finished color has moved to the output registers.
// A two-entry queue sits between the front end and the divider, so points are
// taken while a finished color still waits for the receiver. When m_tready is
// low the output holds, the divider and queue fill, and s_tready drops.
// Reset clears the history, the queue, the output valid and color_mode.

`include "trajectory_autocolor_macros.svh"

module trajectory_autocolor #(
	parameter int POS_BITS   = 16,
	parameter int COLOR_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// Slave stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [((3*POS_BITS+7)/8)*8-1:0] s_tdata,  // pos_x, pos_y, pos_z, zero pad
	input  logic [0:0]  s_tuser,                      // clear_history
	// Master stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [((3*COLOR_BITS+7)/8)*8-1:0] m_tdata, // red, green, blue, zero pad
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import tac_pkg::*;

	localparam int VW     = POS_BITS + 2;
	localparam int QW     = 4 * VW;
	localparam int OUT_DW = ((3*COLOR_BITS+7)/8)*8;

	logic [1:0]            color_mode_q;
	logic                  q_push;
	logic                  q_pop;
	logic [QW-1:0]         q_wdata;
	logic [QW-1:0]         q_rdata;
	tac_qstat_t            q_stat;
	logic [COLOR_BITS-1:0] red;
	logic [COLOR_BITS-1:0] green;
	logic [COLOR_BITS-1:0] blue;

	// The register index is the word address; the byte offset bits are ignored.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_COLOR_MODE) ? {30'd0, color_mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mode_q <= MODE_VEL;
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_COLOR_MODE)) begin
			color_mode_q <= pwdata[1:0];
		end
	end

	tac_front #(
		.POS_BITS(POS_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.color_mode   (color_mode_q),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.pos_x        (s_tdata[POS_BITS-1:0]),
		.pos_y        (s_tdata[2*POS_BITS-1:POS_BITS]),
		.pos_z        (s_tdata[3*POS_BITS-1:2*POS_BITS]),
		.clear_history(s_tuser[0]),
		.q_stat       (q_stat),
		.push         (q_push),
		.push_data    (q_wdata)
	);

	tac_queue #(
		.WIDTH(QW),
		.DEPTH(2)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_wdata),
		.pop      (q_pop),
		.pop_data (q_rdata),
		.q_stat   (q_stat)
	);

	tac_back #(
		.POS_BITS  (POS_BITS),
		.COLOR_BITS(COLOR_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_data (q_rdata),
		.q_stat   (q_stat),
		.pop      (q_pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.red      (red),
		.green    (green),
		.blue     (blue)
	);

	assign m_tdata = OUT_DW'({blue, green, red});

	// The front end never pushes into a full queue.
	`TAC_ASSERT_IMP(a_no_overflow, clk, arst_n, q_push, !q_stat.full, "queue overflow")
	// The divider never pops an empty queue.
	`TAC_ASSERT_IMP(a_no_underflow, clk, arst_n, q_pop, !q_stat.empty, "queue underflow")
	// After a pop the divider is busy and cannot pop again at once.
	`TAC_ASSERT_NXT(a_pop_spacing, clk, arst_n, q_pop, !q_pop, "back-to-back pop")

endmodule
